// File: rtl/hc_pkg.sv
// Shared types, constants and helpers for the Hill cipher encryptor.
// No dependencies; used by every module of the block but hc_checker.
package hc_pkg;

	localparam int MAX_BLOCK = 4;
	localparam int LW = 5;           // letter width
	localparam int KW = 20;          // key row width
	localparam int SW = 12;          // dot product sum width
	localparam logic [LW-1:0] LETTERS = 5'd26;
	localparam logic [LW-1:0] PAD_LETTER = 5'd23;   // 'X'

	// Config register indexes
	localparam logic [2:0] REG_BLOCK_SIZE = 3'd0;
	localparam logic [2:0] REG_KEY_ROW0   = 3'd1;
	localparam logic [2:0] REG_KEY_ROW1   = 3'd2;
	localparam logic [2:0] REG_KEY_ROW2   = 3'd3;
	localparam logic [2:0] REG_KEY_ROW3   = 3'd4;

	// One complete block handed from front to back
	typedef struct packed {
		logic [MAX_BLOCK-1:0][LW-1:0] letters;
		logic [2:0]                   n;
		logic                         done;
	} block_t;

	// Reduce a 5-bit value into 0..25
	function automatic logic [LW-1:0] mod26_small(input logic [LW-1:0] v);
		return (v >= LETTERS) ? v - LETTERS : v;
	endfunction

	// Effective block size: zero reads as one, saturate at MAX_BLOCK
	function automatic logic [2:0] eff_size(input logic [2:0] bs);
		logic [2:0] n;
		n = bs;
		if (n == 3'd0)
			n = 3'd1;
		if (n > 3'(MAX_BLOCK))
			n = 3'(MAX_BLOCK);
		return n;
	endfunction

endpackage

// File: rtl/hill_cipher_encrypt.sv
// Hill cipher encryptor top level: config registers, front end, block
// queue and back end. Depends on hc_pkg, hc_front, hc_queue, hc_back.
//
// Usage:
//  - Config: write cfg_index/cfg_data with cfg_valid; cfg_ready is always
//    high. Index 0 is block_size n (0 acts as 1, above 4 acts as 4),
//    indexes 1..4 are key rows 0..3, entry j at bits 5j+4:5j, taken mod 26.
//    Write only while no request is in flight.
//  - Input: one plaintext letter (0..25, larger codes taken mod 26) per
//    request on in_valid/in_stall. end_of_message pads a partial block
//    with X and flushes it.
//  - Output: each block yields n cipher letters on out_valid/out_stall,
//    last_in_block on the last one, message_done too if the block ended
//    the message.
//  - Timing: a completed block is registered in the queue, and each row
//    then passes the dot-product and mod-26 output stages. Throughput:
//    one letter per cycle in while in_stall is low, one cipher letter per
//    cycle out while out_stall is low, set by one key row issued per cycle.
//  - Reset clears the partial block, the queue and the output stage;
//    block_size returns to 2 and the key to all zero.
//  - A stalled output holds its request; the back end stops, the queue
//    fills, and in_stall rises once both queue entries hold blocks.
module hill_cipher_encrypt (
	input  logic        clk,
	input  logic        arst_n,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	// plaintext channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [4:0]  letter_code,
	input  logic        end_of_message,
	// ciphertext channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  cipher_letter,
	output logic        last_in_block,
	output logic        message_done
);

	logic [2:0]                       block_size_q;
	logic [3:0][hc_pkg::KW-1:0]       key_q;

	logic           q_push;
	logic           q_pop;
	logic           q_full;
	logic           q_empty;
	hc_pkg::block_t q_wr;
	hc_pkg::block_t q_head;

	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q <= 3'd2;
			key_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hc_pkg::REG_BLOCK_SIZE: block_size_q <= cfg_data[2:0];
				hc_pkg::REG_KEY_ROW0:   key_q[0] <= cfg_data;
				hc_pkg::REG_KEY_ROW1:   key_q[1] <= cfg_data;
				hc_pkg::REG_KEY_ROW2:   key_q[2] <= cfg_data;
				hc_pkg::REG_KEY_ROW3:   key_q[3] <= cfg_data;
				default: ;   // unmapped index, write dropped
			endcase
		end
	end

	hc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.letter_code    (letter_code),
		.end_of_message (end_of_message),
		.block_size     (block_size_q),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_entry        (q_wr)
	);

	hc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	hc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.key_rows      (key_q),
		.head          (q_head),
		.empty         (q_empty),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.cipher_letter (cipher_letter),
		.last_in_block (last_in_block),
		.message_done  (message_done)
	);

endmodule

// File: rtl/hc_front.sv
// Front end: takes plaintext letters, collects them into a block, pads on
// end of message and pushes complete blocks to the queue. Uses hc_pkg.
module hc_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [4:0]             letter_code,
	input  logic                   end_of_message,
	input  logic [2:0]             block_size,
	input  logic                   q_full,
	output logic                   q_push,
	output hc_pkg::block_t         q_entry
);

	logic [2:0] fill_q;
	logic [hc_pkg::MAX_BLOCK-1:0][hc_pkg::LW-1:0] buf_q;

	logic [2:0]            n;
	logic [2:0]            f0;
	logic [2:0]            fnext;
	logic [hc_pkg::LW-1:0] letter;
	logic                  accept;
	logic                  complete;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		n        = hc_pkg::eff_size(block_size);
		letter   = hc_pkg::mod26_small(letter_code);
		// stale letters after a block size shrink are dropped
		f0       = (fill_q >= n) ? 3'd0 : fill_q;
		fnext    = f0 + 3'd1;
		complete = (fnext >= n) || end_of_message;
		for (int j = 0; j < hc_pkg::MAX_BLOCK; j++) begin
			if (3'(j) < f0)
				q_entry.letters[j] = buf_q[j];
			else if (3'(j) == f0)
				q_entry.letters[j] = letter;
			else
				q_entry.letters[j] = hc_pkg::PAD_LETTER;
		end
		q_entry.n    = n;
		q_entry.done = end_of_message;
		q_push       = accept && complete;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 3'd0;
		end else if (accept) begin
			fill_q <= complete ? 3'd0 : fnext;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !complete) begin
			buf_q[f0[1:0]] <= letter;
		end
	end

endmodule

// File: rtl/hc_queue.sv
// Two-entry block queue between front and back end.
// Uses hc_pkg::block_t.
module hc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  hc_pkg::block_t wr_entry,
	output logic           full,
	input  logic           pop,
	output hc_pkg::block_t head,
	output logic           empty
);

	hc_pkg::block_t mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

endmodule

// File: rtl/hc_back.sv
// Back end: walks the rows of the head block, one cipher letter per cycle
// unless stalled, via dot-product and mod-26 output stages. Uses hc_pkg.
module hc_back (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [3:0][hc_pkg::KW-1:0]           key_rows,
	input  hc_pkg::block_t                       head,
	input  logic                                 empty,
	output logic                                 pop,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [4:0]                           cipher_letter,
	output logic                                 last_in_block,
	output logic                                 message_done
);

	logic [1:0]            row_q;
	logic                  v_s1;
	logic [hc_pkg::SW-1:0] sum_s1;
	logic                  last_s1;
	logic                  done_s1;
	logic                  v_s2;
	logic [hc_pkg::LW-1:0] letter_s2;
	logic                  last_s2;
	logic                  done_s2;

	logic                  rdy1;
	logic                  rdy2;
	logic                  take;
	logic                  last_row;
	logic [hc_pkg::KW-1:0] krow;
	logic [hc_pkg::SW-1:0] sum;
	logic [hc_pkg::LW-1:0] kent;
	logic [23:0]           recip;
	logic [hc_pkg::SW-1:0] q26;
	logic [hc_pkg::SW-1:0] rem;

	assign rdy2     = !v_s2 || !out_stall;
	assign rdy1     = !v_s1 || rdy2;
	assign take     = rdy1 && !empty;
	assign last_row = ({1'b0, row_q} == head.n - 3'd1);
	assign pop      = take && last_row;

	// row dot product, entries past n masked
	always_comb begin
		krow = key_rows[row_q];
		sum  = '0;
		for (int j = 0; j < hc_pkg::MAX_BLOCK; j++) begin
			kent = hc_pkg::mod26_small(krow[5*j +: 5]);
			if (3'(j) < head.n)
				sum = sum + hc_pkg::SW'(kent * head.letters[j]);
		end
	end

	// sum < 2600: floor(s*2521/2^16) is exactly s/26
	always_comb begin
		recip = 24'(sum_s1) * 24'd2521;
		q26   = hc_pkg::SW'(recip[23:16]) * hc_pkg::SW'(hc_pkg::LETTERS);
		rem   = sum_s1 - q26;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 2'd0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (take)
				row_q <= last_row ? 2'd0 : row_q + 2'd1;
			if (rdy1)
				v_s1 <= take;
			if (rdy2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && take) begin
			sum_s1  <= sum;
			last_s1 <= last_row;
			done_s1 <= last_row && head.done;
		end
		if (rdy2 && v_s1) begin
			letter_s2 <= rem[hc_pkg::LW-1:0];
			last_s2   <= last_s1;
			done_s2   <= done_s1;
		end
	end

	assign out_valid     = v_s2;
	assign cipher_letter = letter_s2;
	assign last_in_block = last_s2;
	assign message_done  = done_s2;

endmodule

// File: rtl/hc_checker.sv
// Port-level checks for hill_cipher_encrypt, bound to the top level.
// Depends only on the top level's ports.
module hc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [4:0] cipher_letter,
	input logic       last_in_block,
	input logic       message_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(cipher_letter) && $stable(last_in_block)
			&& $stable(message_done))
		else $error("stalled output changed");

	a_letter_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cipher_letter < 5'd26)
		else $error("cipher letter out of range");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && message_done |-> last_in_block)
		else $error("message end not on block end");

endmodule

bind hill_cipher_encrypt hc_checker u_hc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.cipher_letter (cipher_letter),
	.last_in_block (last_in_block),
	.message_done  (message_done)
);

// File: sim/tb_top.sv
// Self-checking bench for the Hill cipher encryptor: directed table, then random letters.
// Holds its own cipher predictor and expected-letter queue.
// Depends on hc_pkg and hill_cipher_encrypt.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          SETTLE_CYCLES  = 8;     // margin for the back end to drain
	localparam int          HOLD_CYCLES    = 60;    // long receiver hold-off
	localparam int          WATCHDOG_LIMIT = 1000;  // cycles with no handshake at all
	localparam int          RAND_SEGMENTS  = 8;
	localparam int          SEG_LETTERS    = 47;
	localparam int          PRESS_LETTERS  = 24;
	localparam logic [2:0]  REG_SPARE      = 3'd7;  // unmapped index, must be ignored

	typedef enum logic [1:0] {MODE_NONE, MODE_SENDER, MODE_RECEIVER, MODE_BOTH} idle_mode_t;
	typedef enum logic {ROW_LETTER, ROW_CFG} row_kind_t;

	// One directed step: a register write or a letter. exp is typed in only
	// where the cipher letter is obvious; otherwise the predictor decides.
	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  addr;
		logic [19:0] value;
		logic        eom;
		logic        typed;
		logic [4:0]  exp;
	} plan_row_t;

	typedef struct packed {
		logic [4:0] letter;
		logic       last;
		logic       done;
	} cipher_res_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        cfg_valid      = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index      = '0;
	logic [19:0] cfg_data       = '0;
	logic        in_valid       = 1'b0;
	logic        in_stall;
	logic [4:0]  letter_code    = '0;
	logic        end_of_message = 1'b0;
	logic        out_valid;
	logic        out_stall      = 1'b0;
	logic [4:0]  cipher_letter;
	logic        last_in_block;
	logic        message_done;

	hill_cipher_encrypt dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.letter_code    (letter_code),
		.end_of_message (end_of_message),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.cipher_letter  (cipher_letter),
		.last_in_block  (last_in_block),
		.message_done   (message_done)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Predictor state: shadow registers and the plaintext block being built
	// ---------------------------------------------------------------------
	logic [2:0]  blk_size = 3'd2;
	logic [19:0] key_rows [4] = '{default: '0};
	logic [4:0]  plain_buf [hc_pkg::MAX_BLOCK];
	int          fill_level = 0;
	cipher_res_t expected_q [$];
	int          errors = 0;

	// typed-in expectation for the letter currently offered
	logic        row_typed = 1'b0;
	logic [4:0]  row_typed_cipher = '0;

	// idling controls
	int sink_stall_pct = 0;
	int src_idle_pct   = 0;
	int hold_reqs = 0, hold_acks = 0, hold_left = 0;
	int idle_cycles = 0;

	// Take one plaintext letter; on a full block or end of message, queue
	// the n cipher letters the block must produce.
	function automatic void encrypt_letter(input logic [4:0] code, input logic eom);
		int n, f, i, j, acc, ent;
		cipher_res_t res;
		n = (blk_size == 3'd0) ? 1 :
		    (int'(blk_size) > hc_pkg::MAX_BLOCK) ? hc_pkg::MAX_BLOCK : int'(blk_size);
		f = fill_level;
		// block size shrunk under a partial block: stale letters are dropped
		if (f >= n)
			f = 0;
		plain_buf[f] = 5'(int'(code) % 26);
		f++;
		if (f < n && !eom) begin
			fill_level = f;
			return;
		end
		// partial block at end of message is padded with X
		for (; f < n; f++)
			plain_buf[f] = hc_pkg::PAD_LETTER;
		for (i = 0; i < n; i++) begin
			acc = 0;
			for (j = 0; j < n; j++) begin
				ent = int'(key_rows[i][5*j +: 5]) % 26;   // entries 26..31 wrap
				acc += ent * int'(plain_buf[j]);
			end
			res.letter = row_typed ? row_typed_cipher : 5'(acc % 26);
			res.last   = (i == n - 1);
			res.done   = (i == n - 1) && eom;
			expected_q.push_back(res);
		end
		fill_level = 0;
	endfunction

	// Monitor: every handshake is seen here at the clock edge, so the
	// predictor and the checker never race the stimulus.
	always @(posedge clk) begin
		cipher_res_t exp_res, got_res;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					hc_pkg::REG_BLOCK_SIZE: blk_size    = cfg_data[2:0];
					hc_pkg::REG_KEY_ROW0:   key_rows[0] = cfg_data;
					hc_pkg::REG_KEY_ROW1:   key_rows[1] = cfg_data;
					hc_pkg::REG_KEY_ROW2:   key_rows[2] = cfg_data;
					hc_pkg::REG_KEY_ROW3:   key_rows[3] = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				encrypt_letter(letter_code, end_of_message);
			if (out_valid && !out_stall) begin
				got_res = '{cipher_letter, last_in_block, message_done};
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected cipher letter %0d last %0b done %0b",
						$time, got_res.letter, got_res.last, got_res.done);
					errors++;
				end else begin
					exp_res = expected_q.pop_front();
					if (got_res.letter !== exp_res.letter || got_res.last !== exp_res.last ||
					    got_res.done !== exp_res.done) begin
						$display("%0t: expected letter %0d last %0b done %0b, got letter %0d last %0b done %0b",
							$time, exp_res.letter, exp_res.last, exp_res.done,
							got_res.letter, got_res.last, got_res.done);
						errors++;
					end
				end
			end
		end
	end

	// Receiver: random stall per cycle, or a long hold-off when asked for.
	// The hold is counted here so the sender keeps pushing into a full block.
	always @(negedge clk) begin
		if (hold_left == 0 && hold_acks != hold_reqs) begin
			hold_acks = hold_reqs;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
		end
	end

	// Watchdog: a hung handshake on any channel ends the run
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
		    (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// All tasks are entered and left at a falling edge.
	task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Offer one letter request; valid stays high after acceptance so that
	// back-to-back requests never toggle it inside one time step.
	task automatic send_letter(input logic [4:0] code, input logic eom,
	                           input logic typed, input logic [4:0] typed_val);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid         <= 1'b1;
		letter_code      <= code;
		end_of_message   <= eom;
		row_typed        = typed;
		row_typed_cipher = typed_val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Stop sending, wait for every expected letter, then let a partial
	// block settle inside the block before anything is reconfigured.
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	// Directed table: reset state, extreme codes and keys, size wraps,
	// padding, and a size shrink under a partial block.
	plan_row_t plan [39] = '{
		// after reset n=2 and an all-zero key: every cipher letter is A
		'{ROW_LETTER, '0,                     20'd0,     1'b0, 1'b1, 5'd0},
		'{ROW_LETTER, '0,                     20'd25,    1'b0, 1'b1, 5'd0},
		'{ROW_LETTER, '0,                     20'd31,    1'b1, 1'b1, 5'd0}, // code above Z, padded
		// n=1, identity key: letter passes through mod 26
		'{ROW_CFG,    hc_pkg::REG_BLOCK_SIZE, 20'd1,     1'b0, 1'b0, 5'd0},
		'{ROW_CFG,    hc_pkg::REG_KEY_ROW0,   20'd1,     1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd31,    1'b0, 1'b1, 5'd5},
		'{ROW_LETTER, '0,                     20'd0,     1'b1, 1'b1, 5'd0},
		// key entry 25 negates the letter
		'{ROW_CFG,    hc_pkg::REG_KEY_ROW0,   20'd25,    1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd25,    1'b0, 1'b1, 5'd1},
		'{ROW_LETTER, '0,                     20'd1,     1'b0, 1'b1, 5'd25},
		// key entry 31 acts as 5
		'{ROW_CFG,    hc_pkg::REG_KEY_ROW0,   20'd31,    1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd1,     1'b0, 1'b1, 5'd5},
		// full 4x4 key, all-ones row among them
		'{ROW_CFG,    hc_pkg::REG_BLOCK_SIZE, 20'd4,     1'b0, 1'b0, 5'd0},
		'{ROW_CFG,    hc_pkg::REG_KEY_ROW0,   20'hFFFFF, 1'b0, 1'b0, 5'd0},
		'{ROW_CFG,    hc_pkg::REG_KEY_ROW1,   20'h5A3C7, 1'b0, 1'b0, 5'd0},
		'{ROW_CFG,    hc_pkg::REG_KEY_ROW2,   20'h08421, 1'b0, 1'b0, 5'd0},
		'{ROW_CFG,    hc_pkg::REG_KEY_ROW3,   20'hCB2D9, 1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd3,     1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd7,     1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd11,    1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd30,    1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd12,    1'b1, 1'b0, 5'd0}, // three pad letters
		// size zero reads as one
		'{ROW_CFG,    hc_pkg::REG_BLOCK_SIZE, 20'd0,     1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd9,     1'b0, 1'b0, 5'd0},
		// size seven saturates to four
		'{ROW_CFG,    hc_pkg::REG_BLOCK_SIZE, 20'd7,     1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd2,     1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd4,     1'b1, 1'b0, 5'd0},
		// two letters of a 3-block, then shrink to 2: stale letters dropped
		'{ROW_CFG,    hc_pkg::REG_BLOCK_SIZE, 20'd3,     1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd5,     1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd6,     1'b0, 1'b0, 5'd0},
		'{ROW_CFG,    hc_pkg::REG_BLOCK_SIZE, 20'd2,     1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd8,     1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd10,    1'b0, 1'b0, 5'd0},
		// write to an unmapped index changes nothing
		'{ROW_CFG,    REG_SPARE,              20'hFFFFF, 1'b0, 1'b0, 5'd0},
		'{ROW_CFG,    hc_pkg::REG_BLOCK_SIZE, 20'd3,     1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd20,    1'b1, 1'b0, 5'd0}, // message of one letter
		'{ROW_LETTER, '0,                     20'd14,    1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd15,    1'b0, 1'b0, 5'd0},
		'{ROW_LETTER, '0,                     20'd16,    1'b1, 1'b0, 5'd0}  // full block ends message
	};

	initial begin
		int seg, k, r;
		repeat (10)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain();
				write_reg(plan[i].addr, plan[i].value);
			end else begin
				send_letter(plan[i].value[4:0], plan[i].eom, plan[i].typed, plan[i].exp);
			end
		end

		// Random segments: fresh config, then letters under one idling mode.
		// Partial blocks left at a segment end meet the new size.
		for (seg = 0; seg < RAND_SEGMENTS; seg++) begin
			drain();
			src_idle_pct   = 0;
			sink_stall_pct = 0;
			if ($urandom_range(0, 3) == 0)
				write_reg(hc_pkg::REG_BLOCK_SIZE, 20'($urandom_range(0, 7)));
			else
				write_reg(hc_pkg::REG_BLOCK_SIZE, 20'($urandom_range(1, 4)));
			for (r = 0; r < hc_pkg::MAX_BLOCK; r++)
				if ($urandom_range(0, 3) != 0)
					write_reg(3'(hc_pkg::REG_KEY_ROW0 + r), 20'($urandom));
			unique case (idle_mode_t'(seg % 4))
				MODE_SENDER:   src_idle_pct = 74;
				MODE_RECEIVER: sink_stall_pct = 74;
				MODE_BOTH: begin
					src_idle_pct   = 29;
					sink_stall_pct = 29;
				end
				default: ;
			endcase
			for (k = 0; k < SEG_LETTERS; k++)
				send_letter(5'($urandom_range(0, 31)), $urandom_range(0, 7) == 0, 1'b0, '0);

			// back pressure: receiver holds off while requests keep coming,
			// so the block queue fills and in_stall rises; then pause until
			// every expected letter is out
			if (seg == 2) begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
				hold_reqs++;
				for (k = 0; k < PRESS_LETTERS; k++)
					send_letter(5'($urandom_range(0, 31)), $urandom_range(0, 7) == 0, 1'b0, '0);
				drain();
			end
		end

		drain();
		if (errors == 0 && expected_q.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
